// File: hdl/pra_pkg.sv
`default_nettype none
// ============================================================================
// pra_pkg
// Shared types, codes and default sizes for the refcounted page allocator.
// ============================================================================
package pra_pkg;

   // default sizes
   localparam int PAGE_COUNT_DEF = 4096;
   localparam int PAGE_BYTES_DEF = 4096;
   localparam int COUNT_BITS_DEF = 8;

   // fixed field widths
   localparam int ADDR_W   = 24;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int RCNT_W   = 8;
   localparam int FUP_W    = 12;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 2;
   // wide enough to compare page numbers against a page count of 65536
   localparam int CMP_W    = 17;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INIT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FREE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ADD   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DROP  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_INIT
   } state_type;

endpackage
`default_nettype wire

// File: hdl/pra_ram.sv
`default_nettype none
// ============================================================================
// pra_ram
// Single-port-write, single-port-read memory with registered read data.
// ============================================================================
module pra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/pra_ctrl.sv
`default_nettype none
// ============================================================================
// pra_ctrl
// Sequencer: address check, count read-modify-write, stack push/pop,
// init and reset sweeps, result register.
// ============================================================================
module pra_ctrl #(
   parameter int PAGE_COUNT = pra_pkg::PAGE_COUNT_DEF,
   parameter int PAGE_BYTES = pra_pkg::PAGE_BYTES_DEF,
   parameter int COUNT_BITS = pra_pkg::COUNT_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [pra_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [pra_pkg::ADDR_W-1:0]      req_address,
   // response
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [pra_pkg::STATUS_W-1:0]    rsp_status,
   output      logic [pra_pkg::ADDR_W-1:0]      rsp_page_address,
   output      logic [pra_pkg::RCNT_W-1:0]      rsp_ref_count,
   output      logic                            rsp_returned_to_pool,
   // config
   input  wire logic [pra_pkg::FUP_W-1:0]       first_usable_page,
   // count memory
   output      logic                            cnt_wr_en,
   output      logic [$clog2(PAGE_COUNT)-1:0]   cnt_wr_addr,
   output      logic [COUNT_BITS-1:0]           cnt_wr_data,
   output      logic                            cnt_rd_en,
   output      logic [$clog2(PAGE_COUNT)-1:0]   cnt_rd_addr,
   input  wire logic [COUNT_BITS-1:0]           cnt_rd_data,
   // free stack memory
   output      logic                            stk_wr_en,
   output      logic [$clog2(PAGE_COUNT)-1:0]   stk_wr_addr,
   output      logic [$clog2(PAGE_COUNT)-1:0]   stk_wr_data,
   output      logic                            stk_rd_en,
   output      logic [$clog2(PAGE_COUNT)-1:0]   stk_rd_addr,
   input  wire logic [$clog2(PAGE_COUNT)-1:0]   stk_rd_data
);

   localparam int PIDX_W   = $clog2(PAGE_COUNT);
   localparam int TOP_W    = $clog2(PAGE_COUNT + 1);
   localparam int PB_SHIFT = $clog2(PAGE_BYTES);
   localparam int PN_W     = pra_pkg::ADDR_W - PB_SHIFT;
   localparam int CMP_W    = pra_pkg::CMP_W;

   localparam logic [PIDX_W-1:0]     LAST_PAGE = PIDX_W'(PAGE_COUNT - 1);
   localparam logic [TOP_W-1:0]      TOP_FULL  = TOP_W'(PAGE_COUNT);
   localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

   pra_pkg::state_type state_ff, state_in;

   logic [PIDX_W-1:0]              sweep_ff, sweep_in;
   logic [TOP_W-1:0]               top_ff, top_in;
   logic [pra_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [PIDX_W-1:0]              page_ff, page_in;
   logic                           ok_ff, ok_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pra_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [pra_pkg::ADDR_W-1:0]     paddr_ff, paddr_in;
   logic [pra_pkg::RCNT_W-1:0]     rcnt_ff, rcnt_in;
   logic                           pushed_ff, pushed_in;

   // request address check
   logic [PN_W-1:0]  req_pn;
   logic [CMP_W-1:0] req_pn_wide;
   logic             req_ok;
   logic             accept;
   logic             load;
   logic             sweep_hit;
   logic [COUNT_BITS-1:0] cnt_next;

   assign req_pn      = req_address[pra_pkg::ADDR_W-1:PB_SHIFT];
   assign req_pn_wide = CMP_W'(req_pn);
   assign req_ok      = (req_address[PB_SHIFT-1:0] == '0)
                        && (req_pn_wide >= CMP_W'(first_usable_page))
                        && (req_pn_wide < CMP_W'(PAGE_COUNT));

   assign req_ready = (state_ff == pra_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == pra_pkg::S_EXEC) && (!rsp_valid_ff || rsp_ready);
   // during init, pages at or above the first usable page go to the pool
   assign sweep_hit = (state_ff == pra_pkg::S_INIT)
                      && (CMP_W'(sweep_ff) >= CMP_W'(first_usable_page));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pra_pkg::S_CLEAR;
         sweep_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      page_ff   <= page_in;
      ok_ff     <= ok_in;
      status_ff <= status_in;
      paddr_ff  <= paddr_in;
      rcnt_ff   <= rcnt_in;
      pushed_ff <= pushed_in;
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      top_in       = top_ff;
      kind_in      = kind_ff;
      page_in      = page_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      paddr_in     = paddr_ff;
      rcnt_in      = rcnt_ff;
      pushed_in    = pushed_ff;

      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = page_ff;
      cnt_wr_data  = CNT_ONE;
      cnt_rd_en    = accept;
      cnt_rd_addr  = PIDX_W'(req_pn);
      stk_wr_en    = 1'b0;
      stk_wr_addr  = top_ff[PIDX_W-1:0];
      stk_wr_data  = page_ff;
      stk_rd_en    = accept;
      stk_rd_addr  = PIDX_W'(top_ff - TOP_W'(1));
      cnt_next     = cnt_rd_data;

      case (state_ff)
         pra_pkg::S_CLEAR, pra_pkg::S_INIT: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = sweep_ff;
            cnt_wr_data = sweep_hit ? '0 : CNT_ONE;
            if (sweep_hit) begin
               stk_wr_en   = 1'b1;
               stk_wr_data = sweep_ff;
               top_in      = top_ff + TOP_W'(1);
            end
            if (sweep_ff == LAST_PAGE) begin
               sweep_in = '0;
               state_in = (state_ff == pra_pkg::S_INIT) ? pra_pkg::S_EXEC
                                                        : pra_pkg::S_IDLE;
            end else begin
               sweep_in = sweep_ff + PIDX_W'(1);
            end
         end

         pra_pkg::S_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               page_in = PIDX_W'(req_pn);
               ok_in   = req_ok;
               if (req_kind == pra_pkg::KIND_INIT) begin
                  top_in   = '0;
                  state_in = pra_pkg::S_INIT;
               end else begin
                  state_in = pra_pkg::S_EXEC;
               end
            end
         end

         pra_pkg::S_EXEC: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               status_in    = pra_pkg::STATUS_OK;
               paddr_in     = '0;
               rcnt_in      = '0;
               pushed_in    = 1'b0;
               state_in     = pra_pkg::S_IDLE;
               case (kind_ff)
                  pra_pkg::KIND_ALLOC: begin
                     if (top_ff == '0) begin
                        status_in = pra_pkg::STATUS_EMPTY;
                     end else begin
                        top_in      = top_ff - TOP_W'(1);
                        cnt_wr_en   = 1'b1;
                        cnt_wr_addr = stk_rd_data;
                        cnt_wr_data = CNT_ONE;
                        rcnt_in     = pra_pkg::RCNT_W'(CNT_ONE);
                        paddr_in    = pra_pkg::ADDR_W'(stk_rd_data) << PB_SHIFT;
                     end
                  end
                  pra_pkg::KIND_FREE, pra_pkg::KIND_DROP: begin
                     if (!ok_ff) begin
                        status_in = pra_pkg::STATUS_BAD;
                     end else if (cnt_rd_data == '0) begin
                        status_in = pra_pkg::STATUS_RANGE;
                     end else begin
                        cnt_next    = cnt_rd_data - CNT_ONE;
                        cnt_wr_en   = 1'b1;
                        cnt_wr_data = cnt_next;
                        rcnt_in     = pra_pkg::RCNT_W'(cnt_next);
                        // pool full: count still drops, page stays out
                        if ((kind_ff == pra_pkg::KIND_FREE) && (cnt_next == '0)
                            && (top_ff < TOP_FULL)) begin
                           stk_wr_en = 1'b1;
                           top_in    = top_ff + TOP_W'(1);
                           pushed_in = 1'b1;
                        end
                     end
                  end
                  pra_pkg::KIND_ADD: begin
                     if (!ok_ff) begin
                        status_in = pra_pkg::STATUS_BAD;
                     end else if (cnt_rd_data == CNT_MAX) begin
                        status_in = pra_pkg::STATUS_RANGE;
                        rcnt_in   = pra_pkg::RCNT_W'(cnt_rd_data);
                     end else begin
                        cnt_next    = cnt_rd_data + CNT_ONE;
                        cnt_wr_en   = 1'b1;
                        cnt_wr_data = cnt_next;
                        rcnt_in     = pra_pkg::RCNT_W'(cnt_next);
                     end
                  end
                  pra_pkg::KIND_READ: begin
                     if (!ok_ff) begin
                        status_in = pra_pkg::STATUS_BAD;
                     end else begin
                        rcnt_in = pra_pkg::RCNT_W'(cnt_rd_data);
                     end
                  end
                  default: begin
                     // init result and unused kinds: all zero
                  end
               endcase
            end
         end

         default: begin
            state_in = pra_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_page_address     = paddr_ff;
   assign rsp_ref_count        = rcnt_ff;
   assign rsp_returned_to_pool = pushed_ff;

endmodule
`default_nettype wire

// File: hdl/refcounted_page_allocator_unit.sv
`default_nettype none
// ============================================================================
// refcounted_page_allocator_unit
// Physical page allocator with a LIFO free pool and per-page reference counts.
// ============================================================================
// Each request word carries an operation kind and a page byte address and
// yields exactly one response word. Allocate, free, add-reference,
// drop-reference and read-count each pass through an accept step that
// launches the reads of the count memory and the free stack, then an execute
// step for the read-modify-write of the count and the stack push or pop, both
// memories having registered read data. The next word is taken on the
// cycle after the write-back, so no forwarding is needed. Init sweeps every
// page, one per cycle, writing its count and pushing pages from
// first_usable_page up. After reset the block runs a clearing pass that
// sets every count to one; req_ready stays low until it ends, while register
// writes are taken as usual. A response that is not yet taken holds in the
// output register and the next word is still accepted; that word then waits
// in its execute cycle. PAGE_BYTES must be a power of two.
// first_usable_page is at csr address 0.
// ============================================================================
module refcounted_page_allocator_unit #(
   parameter int PAGE_COUNT = pra_pkg::PAGE_COUNT_DEF,
   parameter int PAGE_BYTES = pra_pkg::PAGE_BYTES_DEF,
   parameter int COUNT_BITS = pra_pkg::COUNT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [pra_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [pra_pkg::ADDR_W-1:0]    req_address,
   // response channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [pra_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [pra_pkg::ADDR_W-1:0]    rsp_page_address,
   output      logic [pra_pkg::RCNT_W-1:0]    rsp_ref_count,
   output      logic                          rsp_returned_to_pool,
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [pra_pkg::PADDR_W-1:0]   csr_paddr,
   input  wire logic [pra_pkg::CSR_W-1:0]     csr_pwdata,
   output      logic [pra_pkg::CSR_W-1:0]     csr_prdata,
   output      logic                          csr_pready
);

   localparam int PIDX_W = $clog2(PAGE_COUNT);

   // first_usable_page register; the only register, so every address maps to it
   logic [pra_pkg::FUP_W-1:0] fup_ff, fup_in;
   logic                      csr_wr;
   logic                      csr_addr_ok;

   assign csr_addr_ok = (csr_paddr == csr_paddr);
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_addr_ok;
   assign fup_in      = csr_wr ? csr_pwdata[pra_pkg::FUP_W-1:0] : fup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fup_ff <= '0;
      end else begin
         fup_ff <= fup_in;
      end
   end

   assign csr_prdata = pra_pkg::CSR_W'(fup_ff);
   assign csr_pready = 1'b1;

   // memory connections
   logic                  cnt_wr_en, cnt_rd_en;
   logic [PIDX_W-1:0]     cnt_wr_addr, cnt_rd_addr;
   logic [COUNT_BITS-1:0] cnt_wr_data, cnt_rd_data;
   logic                  stk_wr_en, stk_rd_en;
   logic [PIDX_W-1:0]     stk_wr_addr, stk_rd_addr;
   logic [PIDX_W-1:0]     stk_wr_data, stk_rd_data;

   pra_ctrl #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_BYTES (PAGE_BYTES),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_address          (req_address),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_page_address     (rsp_page_address),
      .rsp_ref_count        (rsp_ref_count),
      .rsp_returned_to_pool (rsp_returned_to_pool),
      .first_usable_page    (fup_ff),
      .cnt_wr_en            (cnt_wr_en),
      .cnt_wr_addr          (cnt_wr_addr),
      .cnt_wr_data          (cnt_wr_data),
      .cnt_rd_en            (cnt_rd_en),
      .cnt_rd_addr          (cnt_rd_addr),
      .cnt_rd_data          (cnt_rd_data),
      .stk_wr_en            (stk_wr_en),
      .stk_wr_addr          (stk_wr_addr),
      .stk_wr_data          (stk_wr_data),
      .stk_rd_en            (stk_rd_en),
      .stk_rd_addr          (stk_rd_addr),
      .stk_rd_data          (stk_rd_data)
   );

   // per-page reference counts
   pra_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (PAGE_COUNT)
   ) u_count_mem (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // free page stack, last freed on top
   pra_ram #(
      .WIDTH (PIDX_W),
      .DEPTH (PAGE_COUNT)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

endmodule
`default_nettype wire

// File: hdl/pra_checker.sv
`default_nettype none
// ============================================================================
// pra_checker
// Port-level checks of the page allocator, bound to the top level.
// ============================================================================
module pra_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [pra_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [pra_pkg::ADDR_W-1:0]    rsp_page_address,
   input wire logic [pra_pkg::RCNT_W-1:0]    rsp_ref_count,
   input wire logic                          rsp_returned_to_pool,
   input wire logic                          csr_psel,
   input wire logic                          csr_penable,
   input wire logic                          csr_pwrite,
   input wire logic [pra_pkg::CSR_W-1:0]     csr_pwdata,
   input wire logic [pra_pkg::CSR_W-1:0]     csr_prdata
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_page_address) && $stable(rsp_ref_count)
         && $stable(rsp_returned_to_pool))
      else $error("response word changed while stalled");

   // one word at a time: no accept on the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // a push only on a clean free that reached zero
   a_push_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_returned_to_pool |->
         rsp_status == pra_pkg::STATUS_OK && rsp_ref_count == '0
         && rsp_page_address == '0)
      else $error("page pushed on a failed or nonzero free");

   // register write reads back
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=>
         csr_prdata[pra_pkg::FUP_W-1:0] == $past(csr_pwdata[pra_pkg::FUP_W-1:0]))
      else $error("first usable page does not read back");

endmodule

bind refcounted_page_allocator_unit pra_checker u_pra_checker (.*);
`default_nettype wire
